// ===== rtl/core/apu_elc_pkg.sv =====
// apu_elc_pkg: shared types, constants and the length reload table
// for the envelope and length counter block; no dependencies
`timescale 1ns / 1ps

package apu_elc_pkg;

  typedef enum logic [2:0] {
    CMD_CTRL_WR   = 3'd0,
    CMD_LEN_WR    = 3'd1,
    CMD_ENABLE_WR = 3'd2,
    CMD_ENV_TICK  = 3'd3,
    CMD_LEN_TICK  = 3'd4,
    CMD_CYC_TICK  = 3'd5,
    CMD_SOFT_RST  = 3'd6
  } cmd_e;

  localparam logic [3:0] VolMax      = 4'hF;
  localparam int unsigned DivWidth   = 5;
  localparam int unsigned LenWidth   = 8;

  // control register bit positions
  localparam int unsigned CtrlConstBit = 4;
  localparam int unsigned CtrlHaltBit  = 5;

  // length reload table, indexed by write_data[7:3]
  function automatic logic [LenWidth-1:0] len_lookup(input logic [4:0] idx);
    logic [LenWidth-1:0] val;
    case (idx)
      5'd0:  val = 8'h0A;
      5'd1:  val = 8'hFE;
      5'd2:  val = 8'h14;
      5'd3:  val = 8'h02;
      5'd4:  val = 8'h28;
      5'd5:  val = 8'h04;
      5'd6:  val = 8'h50;
      5'd7:  val = 8'h06;
      5'd8:  val = 8'hA0;
      5'd9:  val = 8'h08;
      5'd10: val = 8'h3C;
      5'd11: val = 8'h0A;
      5'd12: val = 8'h0E;
      5'd13: val = 8'h0C;
      5'd14: val = 8'h1A;
      5'd15: val = 8'h0E;
      5'd16: val = 8'h0C;
      5'd17: val = 8'h10;
      5'd18: val = 8'h18;
      5'd19: val = 8'h12;
      5'd20: val = 8'h30;
      5'd21: val = 8'h14;
      5'd22: val = 8'h60;
      5'd23: val = 8'h16;
      5'd24: val = 8'hC0;
      5'd25: val = 8'h18;
      5'd26: val = 8'h48;
      5'd27: val = 8'h1A;
      5'd28: val = 8'h10;
      5'd29: val = 8'h1C;
      5'd30: val = 8'h20;
      5'd31: val = 8'h1E;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/core/apu_elc_if.sv =====
// apu_elc_in_if / apu_elc_out_if: valid/ready channels for event and result beats
// depends on nothing
`timescale 1ns / 1ps

interface apu_elc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] write_data;
  logic       length_clock_now;

  modport source (output valid, output cmd, output write_data, output length_clock_now,
                  input ready);
  modport sink   (input valid, input cmd, input write_data, input length_clock_now,
                  output ready);
endinterface

interface apu_elc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] volume;
  logic       active;

  modport source (output valid, output volume, output active, input ready);
  modport sink   (input valid, input volume, input active, output ready);
endinterface

// ===== rtl/core/apu_envelope_length_counter.sv =====
// apu_envelope_length_counter: volume envelope and length counter of one sound channel
// depends on apu_elc_pkg and the channel interfaces in apu_elc_if.sv
`timescale 1ns / 1ps

// usage
//   in_i  : event beats (cmd, write_data, length_clock_now), valid/ready
//   out_o : one result beat per event (volume, active), valid/ready
//   every accepted event gives exactly one result beat, in order
// timing
//   an event lands in the input register, the state update and result are
//   worked out combinationally from it and captured in the result register,
//   which drives out_o; a stall on out_o can hold the event in between
//   throughput is one event per cycle while out_o.ready stays high, set by
//   the single update stage
// reset
//   rst_ni low clears all envelope and length state to zero and empties both
//   registers; no results are pending afterwards
// stalls
//   while out_o.ready is low the result register holds its beat, the input
//   register still takes one more event, and in_i.ready drops once both are
//   full; nothing is lost or repeated
// unused cmd code 7 changes no state and reports the current outputs

module apu_envelope_length_counter (
  input  logic                clk_i,
  input  logic                rst_ni,
  apu_elc_in_if.sink          in_i,
  apu_elc_out_if.source       out_o
);

  // input register
  logic       in_vld_q;
  logic [2:0] in_cmd_q;
  logic [7:0] in_data_q;
  logic       in_lclk_q;

  // result register
  logic       out_vld_q;
  logic [3:0] out_vol_q;
  logic       out_act_q;

  // channel state
  logic [3:0]                        vol_q, vol_d;
  logic                              restart_q, restart_d;
  logic [3:0]                        level_q, level_d;
  logic [apu_elc_pkg::DivWidth-1:0]  div_q, div_d;
  logic [3:0]                        period_q, period_d;
  logic                              const_q, const_d;
  logic                              halt_q, halt_d;
  logic                              halt_req_q, halt_req_d;
  logic [apu_elc_pkg::LenWidth-1:0]  len_cnt_q, len_cnt_d;
  logic                              len_en_q, len_en_d;
  logic [apu_elc_pkg::LenWidth-1:0]  reload_q, reload_d;
  logic                              pend_q, pend_d;

  logic adv;

  // the update stage moves whenever the input register holds an event and the result register is free or draining
  assign adv        = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || adv;

  assign out_o.valid  = out_vld_q;
  assign out_o.volume = out_vol_q;
  assign out_o.active = out_act_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_cmd_q  <= in_i.cmd;
      in_data_q <= in_i.write_data;
      in_lclk_q <= in_i.length_clock_now;
    end
  end

  // next state for the event in the input register
  always_comb begin
    logic [apu_elc_pkg::DivWidth-1:0] div_reload;
    logic                             upd_vol;
    div_reload = {1'b0, period_q} + apu_elc_pkg::DivWidth'(1);
    upd_vol    = 1'b0;
    restart_d  = restart_q;
    level_d    = level_q;
    div_d      = div_q;
    period_d   = period_q;
    const_d    = const_q;
    halt_d     = halt_q;
    halt_req_d = halt_req_q;
    len_cnt_d  = len_cnt_q;
    len_en_d   = len_en_q;
    reload_d   = reload_q;
    pend_d     = pend_q;
    case (apu_elc_pkg::cmd_e'(in_cmd_q))
      apu_elc_pkg::CMD_CTRL_WR: begin
        period_d   = in_data_q[3:0];
        const_d    = in_data_q[apu_elc_pkg::CtrlConstBit];
        halt_req_d = in_data_q[apu_elc_pkg::CtrlHaltBit];
        upd_vol    = 1'b1;
      end
      apu_elc_pkg::CMD_LEN_WR: begin
        reload_d  = apu_elc_pkg::len_lookup(in_data_q[7:3]);
        pend_d    = 1'b1;
        restart_d = 1'b1;
      end
      apu_elc_pkg::CMD_ENABLE_WR: begin
        len_en_d = in_data_q[0];
        if (!in_data_q[0]) begin
          len_cnt_d = '0;
        end
      end
      apu_elc_pkg::CMD_ENV_TICK: begin
        upd_vol = 1'b1;
        if (restart_q) begin
          restart_d = 1'b0;
          level_d   = apu_elc_pkg::VolMax;
          div_d     = div_reload;
        end else if (div_q != '0) begin
          div_d = div_q - apu_elc_pkg::DivWidth'(1);
        end else begin
          div_d = div_reload;
          if (level_q != '0) begin
            level_d = level_q - 4'd1;
          end else if (halt_q) begin
            level_d = apu_elc_pkg::VolMax;
          end
        end
      end
      apu_elc_pkg::CMD_LEN_TICK: begin
        if (!halt_q && len_cnt_q != '0) begin
          len_cnt_d = len_cnt_q - apu_elc_pkg::LenWidth'(1);
        end
      end
      apu_elc_pkg::CMD_CYC_TICK: begin
        halt_d = halt_req_q;
        // a reload clashing with a length clock on a live counter is dropped
        if (pend_q && !(in_lclk_q && len_cnt_q != '0) && len_en_q) begin
          len_cnt_d = reload_q;
        end
        pend_d = 1'b0;
      end
      apu_elc_pkg::CMD_SOFT_RST: begin
        len_cnt_d = '0;
        len_en_d  = 1'b0;
      end
      default: begin
      end
    endcase
    vol_d = upd_vol ? (const_d ? period_d : level_d) : vol_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q      <= '0;
      restart_q  <= 1'b0;
      level_q    <= '0;
      div_q      <= '0;
      period_q   <= '0;
      const_q    <= 1'b0;
      halt_q     <= 1'b0;
      halt_req_q <= 1'b0;
      len_cnt_q  <= '0;
      len_en_q   <= 1'b0;
      reload_q   <= '0;
      pend_q     <= 1'b0;
    end else if (adv) begin
      vol_q      <= vol_d;
      restart_q  <= restart_d;
      level_q    <= level_d;
      div_q      <= div_d;
      period_q   <= period_d;
      const_q    <= const_d;
      halt_q     <= halt_d;
      halt_req_q <= halt_req_d;
      len_cnt_q  <= len_cnt_d;
      len_en_q   <= len_en_d;
      reload_q   <= reload_d;
      pend_q     <= pend_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_vol_q <= vol_d;
      out_act_q <= (len_cnt_d != '0);
    end
  end

  // checks

  // a disabled length counter always reads zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !len_en_q |-> (len_cnt_q == '0))
    else $error("length count nonzero while disabled");

  // divider never exceeds the largest reload of sixteen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_q <= 5'd16)
    else $error("divider out of range");

  // soft reset always reports an inactive counter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_cmd_q == apu_elc_pkg::CMD_SOFT_RST) |=> (out_vld_q && !out_act_q))
    else $error("active after soft reset");

  // constant mode control write reports the written level at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_cmd_q == apu_elc_pkg::CMD_CTRL_WR && in_data_q[apu_elc_pkg::CtrlConstBit])
    |=> (out_vol_q == $past(in_data_q[3:0])))
    else $error("constant volume not reported");

  // a new result only appears after the update stage moved
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(adv))
    else $error("result without an event");

endmodule
